FILE: rtl/fixed_point_alu_assert.svh
// Assertion macros for the ALU top level
`ifndef FIXED_POINT_ALU_ASSERT_SVH
`define FIXED_POINT_ALU_ASSERT_SVH

// same-cycle implication, off during reset
`define FPA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fixed_point_alu: same-cycle check failed");

// next-cycle implication, checked during reset too
`define FPA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("fixed_point_alu: next-cycle check failed");

`endif

FILE: rtl/fpa_pkg.sv
`default_nettype none
package fpa_pkg;

  localparam logic [3:0] OP_NEG      = 4'd0;
  localparam logic [3:0] OP_ADD      = 4'd1;
  localparam logic [3:0] OP_SUB      = 4'd2;
  localparam logic [3:0] OP_MUL      = 4'd3;
  localparam logic [3:0] OP_DIV      = 4'd4;
  localparam logic [3:0] OP_SHR      = 4'd5;
  localparam logic [3:0] OP_SHL      = 4'd6;
  localparam logic [3:0] OP_LT       = 4'd7;
  localparam logic [3:0] OP_GT       = 4'd8;
  localparam logic [3:0] OP_LE       = 4'd9;
  localparam logic [3:0] OP_GE       = 4'd10;
  localparam logic [3:0] OP_EQ       = 4'd11;
  localparam logic [3:0] OP_NE       = 4'd12;
  localparam logic [3:0] OP_FROM_INT = 4'd13;
  localparam logic [3:0] OP_TO_INT   = 4'd14;

  // divider: 64 quotient bits, four per stage
  localparam int DIV_BITS   = 64;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = DIV_BITS / DIV_STEPS;

  // result fields riding beside the divider
  typedef struct packed {
    logic        valid;
    logic        is_div;
    logic        neg;
    logic        dz;
    logic        flag;
    logic [31:0] res;
  } side_t;

  // divider working state
  typedef struct packed {
    logic [31:0] rem;
    logic [63:0] dq;
    logic [31:0] dvs;
  } div_t;

endpackage
`default_nettype wire

FILE: rtl/fpa_front.sv
`default_nettype none
module fpa_front #(
  parameter int FRAC_BITS = 8
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 en,
  input  wire                 valid_in,
  input  wire  [3:0]          op,
  input  wire  signed [31:0]  a,
  input  wire  signed [31:0]  b,
  input  wire  [4:0]          sh,
  output fpa_pkg::side_t      side_out,
  output fpa_pkg::div_t       div_out
);

  fpa_pkg::side_t     side;
  logic               is_mul;
  logic signed [63:0] prod;
  logic [31:0]        res_c;
  logic               flag_c;
  logic [31:0]        abs_a;
  logic [31:0]        abs_b;

  // simple operations, comparisons and divide setup
  always_comb begin
    res_c  = 32'd0;
    flag_c = 1'b0;
    case (op)
      fpa_pkg::OP_NEG:      res_c = 32'd0 - a;
      fpa_pkg::OP_ADD:      res_c = a + b;
      fpa_pkg::OP_SUB:      res_c = a - b;
      fpa_pkg::OP_SHR:      res_c = a >>> sh;
      fpa_pkg::OP_SHL:      res_c = a << sh;
      fpa_pkg::OP_LT:       flag_c = a < b;
      fpa_pkg::OP_GT:       flag_c = a > b;
      fpa_pkg::OP_LE:       flag_c = a <= b;
      fpa_pkg::OP_GE:       flag_c = a >= b;
      fpa_pkg::OP_EQ:       flag_c = a == b;
      fpa_pkg::OP_NE:       flag_c = a != b;
      fpa_pkg::OP_FROM_INT: res_c = a << FRAC_BITS;
      fpa_pkg::OP_TO_INT:   res_c = a >>> FRAC_BITS;
      default:              res_c = 32'd0;
    endcase
    abs_a = a[31] ? 32'd0 - a : a;
    abs_b = b[31] ? 32'd0 - b : b;
  end

  // register results, product and divider start
  always_ff @(posedge clk) begin
    if (rst) begin
      side.valid <= 1'b0;
    end else if (en) begin
      side.valid <= valid_in;
    end
    if (en) begin
      side.is_div <= (op == fpa_pkg::OP_DIV);
      side.neg    <= a[31] ^ b[31];
      side.dz     <= (op == fpa_pkg::OP_DIV) && (b == 32'sd0);
      side.flag   <= flag_c;
      side.res    <= res_c;
      is_mul      <= (op == fpa_pkg::OP_MUL);
      prod        <= 64'(a) * 64'(b);
      div_out.rem <= 32'd0;
      div_out.dq  <= {32'd0, abs_a} << FRAC_BITS;
      div_out.dvs <= abs_b;
    end
  end

  // scale product back to the fixed-point grid
  always_comb begin
    side_out = side;
    if (is_mul) begin
      side_out.res = prod[FRAC_BITS +: 32];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/fpa_div_stage.sv
`default_nettype none
module fpa_div_stage (
  input  wire             clk,
  input  wire             rst,
  input  wire             en,
  input  fpa_pkg::side_t  side_in,
  input  fpa_pkg::div_t   div_in,
  output fpa_pkg::side_t  side_out,
  output fpa_pkg::div_t   div_out
);

  logic [31:0] rem_w;
  logic [63:0] dq_w;
  logic [32:0] part;
  logic [32:0] diff;

  // restoring steps on magnitudes
  always_comb begin
    rem_w = div_in.rem;
    dq_w  = div_in.dq;
    part  = 33'd0;
    diff  = 33'd0;
    for (int i = 0; i < fpa_pkg::DIV_STEPS; i++) begin
      part = {rem_w, dq_w[63]};
      diff = part - {1'b0, div_in.dvs};
      dq_w = {dq_w[62:0], 1'b0};
      if (part >= {1'b0, div_in.dvs}) begin
        rem_w   = diff[31:0];
        dq_w[0] = 1'b1;
      end else begin
        rem_w = part[31:0];
      end
    end
  end

  // advance one stage
  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.valid <= 1'b0;
    end else if (en) begin
      side_out.valid <= side_in.valid;
    end
    if (en) begin
      side_out.is_div <= side_in.is_div;
      side_out.neg    <= side_in.neg;
      side_out.dz     <= side_in.dz;
      side_out.flag   <= side_in.flag;
      side_out.res    <= side_in.res;
      div_out.rem     <= rem_w;
      div_out.dq      <= dq_w;
      div_out.dvs     <= div_in.dvs;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/fixed_point_alu.sv
// Q-format fixed-point ALU, fully pipelined.
// Pipeline: input register, operate stage, sixteen divider stages of four
// quotient bits each, output register.
// Throughput: one beat per cycle; a stalled output holds the whole pipe.
// Reset: synchronous, active high; clears all valid bits, the pipe is empty.
`default_nettype none
module fixed_point_alu #(
  parameter int FRAC_BITS = 8
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire  [3:0]         opcode,
  input  wire  signed [31:0] operand_a,
  input  wire  signed [31:0] operand_b,
  input  wire  [4:0]         shift_amount,
  output logic               out_valid,
  input  wire                out_ready,
  output logic signed [31:0] result,
  output logic               compare_flag,
  output logic               divide_by_zero
);

  localparam int NS = fpa_pkg::DIV_STAGES;

  logic               en;
  logic               s1_valid;
  logic [3:0]         s1_op;
  logic signed [31:0] s1_a;
  logic signed [31:0] s1_b;
  logic [4:0]         s1_sh;
  fpa_pkg::side_t     side [NS+1];
  fpa_pkg::div_t      dv   [NS+1];
  logic [31:0]        q;

  // whole pipe moves unless the output beat is stalled
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // capture input beat
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
    if (en) begin
      s1_op <= opcode;
      s1_a  <= operand_a;
      s1_b  <= operand_b;
      s1_sh <= shift_amount;
    end
  end

  fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst(rst), .en(en), .valid_in(s1_valid),
    .op(s1_op), .a(s1_a), .b(s1_b), .sh(s1_sh),
    .side_out(side[0]), .div_out(dv[0])
  );

  for (genvar g = 0; g < NS; g++) begin : g_div
    fpa_div_stage u_stage (
      .clk(clk), .rst(rst), .en(en),
      .side_in(side[g]), .div_in(dv[g]),
      .side_out(side[g+1]), .div_out(dv[g+1])
    );
  end

  // apply quotient sign
  assign q = side[NS].neg ? 32'd0 - dv[NS].dq[31:0] : dv[NS].dq[31:0];

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= side[NS].valid;
    end
    if (en) begin
      compare_flag   <= side[NS].flag;
      divide_by_zero <= side[NS].dz;
      if (side[NS].is_div) begin
        result <= side[NS].dz ? 32'sd0 : q;
      end else begin
        result <= side[NS].res;
      end
    end
  end

`include "fixed_point_alu_assert.svh"

  `FPA_ASSERT_NEXT(a_reset_empty, rst, !out_valid)
  `FPA_ASSERT_NOW(a_flag_zero_res, out_valid && compare_flag, result == 32'sd0)
  `FPA_ASSERT_NOW(a_dz_clean, out_valid && divide_by_zero, result == 32'sd0 && !compare_flag)
  `FPA_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(result))

endmodule
`default_nettype wire

FILE: tb/alu_checker.sv
`timescale 1ns / 100ps
module alu_checker #(
  parameter int FRAC_BITS = 8
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  input  wire               in_ready,
  input  wire        [3:0]  opcode,
  input  wire signed [31:0] operand_a,
  input  wire signed [31:0] operand_b,
  input  wire        [4:0]  shift_amount,
  input  wire               out_valid,
  input  wire               out_ready,
  input  wire signed [31:0] result,
  input  wire               compare_flag,
  input  wire               divide_by_zero,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic [31:0] res;
    logic        flag;
    logic        dz;
  } alu_out_t;

  alu_out_t answers[$];

  initial fail_count = 0;
  assign pending = answers.size();

  // compute the expected outcome of one operation
  function automatic alu_out_t alu_predict(logic [3:0] op, logic signed [31:0] a,
                                           logic signed [31:0] b, logic [4:0] sh);
    alu_out_t o;
    logic signed [63:0] wide;
    logic signed [63:0] num;
    o = '0;
    case (op)
      fpa_pkg::OP_NEG: o.res = -a;
      fpa_pkg::OP_ADD: o.res = a + b;
      fpa_pkg::OP_SUB: o.res = a - b;
      fpa_pkg::OP_MUL: begin
        wide = 64'(a) * 64'(b);
        wide = wide >>> FRAC_BITS;
        o.res = wide[31:0];
      end
      fpa_pkg::OP_DIV: begin
        if (b == 0) begin
          o.dz = 1'b1;
        end else begin
          num = 64'(a) <<< FRAC_BITS;
          wide = num / 64'(b);
          o.res = wide[31:0];
        end
      end
      fpa_pkg::OP_SHR: o.res = a >>> sh;
      fpa_pkg::OP_SHL: o.res = a << sh;
      fpa_pkg::OP_LT: o.flag = a < b;
      fpa_pkg::OP_GT: o.flag = a > b;
      fpa_pkg::OP_LE: o.flag = a <= b;
      fpa_pkg::OP_GE: o.flag = a >= b;
      fpa_pkg::OP_EQ: o.flag = a == b;
      fpa_pkg::OP_NE: o.flag = a != b;
      fpa_pkg::OP_FROM_INT: o.res = a << FRAC_BITS;
      fpa_pkg::OP_TO_INT: o.res = a >>> FRAC_BITS;
      default: o = '0;
    endcase
    return o;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // queue input beats, compare output beats
  always @(posedge clk) begin
    alu_out_t w;
    if (!rst) begin
      if (in_valid && in_ready)
        answers.push_back(alu_predict(opcode, operand_a, operand_b, shift_amount));
      if (out_valid && out_ready) begin
        if (answers.size() == 0) begin
          report("unexpected beat", result, 32'd0);
        end else begin
          w = answers.pop_front();
          if (result !== w.res) report("result", result, w.res);
          if (compare_flag !== w.flag)
            report("compare_flag", 32'(compare_flag), 32'(w.flag));
          if (divide_by_zero !== w.dz)
            report("divide_by_zero", 32'(divide_by_zero), 32'(w.dz));
        end
      end
    end
  end
endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
module testbench;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic        [3:0]  opcode = '0;
  logic signed [31:0] operand_a = '0;
  logic signed [31:0] operand_b = '0;
  logic        [4:0]  shift_amount = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] result;
  logic               compare_flag;
  logic               divide_by_zero;
  int                 fail_count;
  int                 pending;
  bit                 calm = 1'b0;

  always #5 clk = ~clk;

  fixed_point_alu u_dut (.*);

  alu_checker u_chk (.*);

  // pick an operand, often at or near an edge
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(int'($urandom_range(0, 6)) - 3);
      3: return 32'($urandom_range(0, 65535)) ^ {32{1'($urandom)}};
      default: return $urandom;
    endcase
  endfunction

  // present one beat and hold it until accepted
  task automatic send(logic [3:0] op, logic [31:0] a, logic [31:0] b, logic [4:0] sh);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    operand_a <= a;
    operand_b <= b;
    shift_amount <= sh;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stall the output side in bursts
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 16);
      end else begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 20);
      end
      repeat (n) @(posedge clk);
    end
  end

  initial begin
    #20ms;
    $display("testbench: errors");
    $finish;
  end

  initial begin
    logic [31:0] ext[4];
    logic [3:0]  op;
    int          tail;
    ext[0] = 32'h8000_0000;
    ext[1] = 32'h7fff_ffff;
    ext[2] = 32'h0;
    ext[3] = 32'hffff_ffff;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: every opcode at the extremes, divide by zero, unused opcode
    for (int k = 0; k < 15; k++)
      send(4'(k), ext[k % 4], ext[(k + 1) % 4], 5'(k * 2 + 1));
    send(fpa_pkg::OP_DIV, 32'h0000_0100, 32'h0, 5'd0);
    send(fpa_pkg::OP_DIV, 32'h8000_0000, 32'hffff_ffff, 5'd31);
    send(fpa_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000, 5'd0);
    send(fpa_pkg::OP_SHR, 32'h8000_0000, 32'h0, 5'd31);
    send(fpa_pkg::OP_SHL, 32'h7fff_ffff, 32'h0, 5'd31);
    send(fpa_pkg::OP_SHR, 32'h8765_4321, 32'h0, 5'd0);
    send(fpa_pkg::OP_EQ, 32'h1234_5678, 32'h1234_5678, 5'd0);
    send(4'hf, 32'hdead_beef, 32'hcafe_f00d, 5'd31);
    // random operations
    for (int i = 0; i < 1650; i++) begin
      if (i == 1450) calm = 1'b1;
      op = ($urandom_range(0, 40) == 0) ? 4'hf : 4'($urandom_range(0, 14));
      send(op, pick_word(), ($urandom_range(0, 15) == 0) ? 32'h0 : pick_word(),
           5'($urandom));
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    tail = 0;
    while (tail < 40) begin
      @(posedge clk);
      tail++;
    end
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
